// ===== hdl/ossc_pkg.sv =====
// Shared types, constants and table functions of the step size controller.
`timescale 1ns / 1ps
package ossc_pkg;

    localparam int C_ROOT_TABLE_BITS = 8;

    localparam int ERR_W   = 32;
    localparam int STEP_W  = 48;
    localparam int ROOT_W  = 17;
    localparam int SCALE_W = 20;
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 20;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int LZ_W    = 5;
    localparam int EXP_W   = 6;
    localparam int ACC_W   = 52;
    localparam int SUM_W   = ACC_W + 1;

    // Scale constants, unsigned Q4.16
    localparam logic [SCALE_W-1:0] SC_ONE  = 20'd65536;
    localparam logic [SCALE_W-1:0] SC_MIN  = 20'd21823;
    localparam logic [SCALE_W-1:0] SC_MAX  = 20'd393216;
    localparam logic [SCALE_W-1:0] SC_NINE = 20'd58982;

    localparam logic [ERR_W-1:0]  ERR_ONE  = 32'd65536;
    localparam logic [STEP_W-1:0] STEP_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [ERR_W-1:0]  error_estimate;
        logic [STEP_W-1:0] tried_step;
    } t_in_item;

    typedef struct packed {
        logic              step_accepted;
        logic [STEP_W-1:0] new_step;
        logic              step_saturated;
    } t_out_item;

    typedef struct packed {
        logic            done;
        logic [LZ_W-1:0] lead_zeros;
    } t_norm_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NORM,
        S_ROOT,
        S_MUL_TR,
        S_MUL_NINE,
        S_SCALE,
        S_MUL_HI,
        S_MUL_LO,
        S_DONE
    } t_seq_state;

    // 2^(r/8) in Q1.16, rounded to nearest
    function automatic logic [ROOT_W-1:0] pow2_eighth(input logic [2:0] r);
        logic [ROOT_W-1:0] v;
        case (r)
            3'd0:    v = 17'd65536;
            3'd1:    v = 17'd71468;
            3'd2:    v = 17'd77936;
            3'd3:    v = 17'd84990;
            3'd4:    v = 17'd92682;
            3'd5:    v = 17'd101070;
            3'd6:    v = 17'd110218;
            3'd7:    v = 17'd120194;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

    function automatic longint unsigned sq16(input longint unsigned a);
        return (a * a + 64'd32768) >> 16;
    endfunction

    // Largest y in [0, 1.0] (Q1.16) whose eighth power stays at or below the
    // reciprocal of the bucket midpoint; evaluated at elaboration only.
    function automatic logic [ROOT_W-1:0] root_entry(input int unsigned bits,
                                                      input int unsigned idx);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned mult;
        longint unsigned lim;
        longint unsigned p8;
        lo   = 64'd0;
        hi   = 64'd65536;
        mult = (64'd1 << (bits + 1)) + 64'd2 * longint'(idx) + 64'd1;
        lim  = 64'd1 << (17 + bits);
        while (lo < hi) begin
            mid = (lo + hi + 64'd1) >> 1;
            p8  = sq16(sq16(sq16(mid)));
            if (p8 * mult <= lim) begin
                lo = mid;
            end else begin
                hi = mid - 64'd1;
            end
        end
        return lo[ROOT_W-1:0];
    endfunction

endpackage

// ===== hdl/ode_step_size_controller_unit.sv =====
// Top level of the step size controller: sequencer around a shared multiplier.
`timescale 1ns / 1ps
// Takes one beat of (error_estimate Q16.16, tried_step Q16.32) and returns one beat of
// (step_accepted, new_step Q16.32, step_saturated). The step is accepted when the error
// is at most 1.0; the scale 0.9*error^(-1/8) comes from a root table indexed by the
// normalised error and a 2^(r/8) factor, clamped to [0.333, 6] (capped at 1.0 after a
// rejected step; rejects only hold the lower bound). Each item runs through a five-step
// normaliser, a table read and four passes through the single shared multiplier; a zero
// error skips the normaliser, the table and the first two passes. The input stalls until
// the result is registered. The result sits in an output register, so a new beat is taken
// while an earlier result waits; the next result is held back until that register is free.
module ode_step_size_controller_unit #(
    parameter int ROOT_TABLE_BITS = ossc_pkg::C_ROOT_TABLE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  ossc_pkg::t_in_item    i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output ossc_pkg::t_out_item   o_out
);
    import ossc_pkg::*;

    t_seq_state        r_state, n_state;
    logic              r_out_valid, n_out_valid;
    logic              r_last_rej, n_last_rej;

    t_out_item         r_out, n_out;
    logic [STEP_W-1:0] r_step_in, n_step_in;
    logic              r_accept, n_accept;
    logic              r_zero, n_zero;
    logic [EXP_W-1:0]  r_u, n_u;
    logic [SCALE_W-1:0] r_scale, n_scale;
    logic [ACC_W-1:0]  r_acc, n_acc;

    t_norm_status      w_norm_stat;
    logic [ERR_W-1:0]  w_mant;
    logic              w_norm_load;
    logic [ROOT_W-1:0] w_root;
    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic [MUL_P_W-1:0] w_prod;

    logic [EXP_W-1:0]   w_sh;
    logic [MUL_P_W-1:0] w_shifted;
    logic [SCALE_W-1:0] w_scale;
    logic [SUM_W-1:0]   w_sum;
    logic               w_sat;
    logic [STEP_W-1:0]  w_res;
    logic               w_in_take;

    assign w_in_take   = (r_state == S_IDLE) && i_in_valid;
    assign w_norm_load = w_in_take && (i_in.error_estimate != '0);

    ossc_normalizer u_norm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_norm_load),
        .i_value  (i_in.error_estimate),
        .o_status (w_norm_stat),
        .o_mant   (w_mant)
    );

    ossc_root_rom #(
        .ROOT_TABLE_BITS (ROOT_TABLE_BITS)
    ) u_root (
        .i_clk  (i_clk),
        .i_addr (w_mant[ERR_W-2 -: ROOT_TABLE_BITS]),
        .o_data (w_root)
    );

    ossc_mul_unit u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // Multiplier operand selection per sequencer step
    always_comb begin
        case (r_state)
            S_MUL_TR: begin
                w_mul_a = MUL_A_W'(w_root);
                w_mul_b = MUL_B_W'(pow2_eighth(r_u[2:0]));
            end
            S_MUL_NINE: begin
                w_mul_a = w_prod[MUL_A_W-1:0];
                w_mul_b = SC_NINE;
            end
            S_MUL_HI: begin
                w_mul_a = MUL_A_W'(r_step_in[STEP_W-1:16]);
                w_mul_b = r_scale;
            end
            S_MUL_LO, S_DONE: begin
                w_mul_a = MUL_A_W'(r_step_in[15:0]);
                w_mul_b = r_scale;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Scale from the triple product, then clamp
    always_comb begin
        w_sh      = 6'd34 - {3'b000, r_u[5:3]};
        w_shifted = w_prod >> w_sh;
        w_scale   = r_zero ? SC_MAX : w_shifted[SCALE_W-1:0];
        if (r_accept) begin
            if (w_scale > SC_MAX) begin
                w_scale = SC_MAX;
            end
            if (w_scale < SC_MIN) begin
                w_scale = SC_MIN;
            end
            if (r_last_rej && (w_scale > SC_ONE)) begin
                w_scale = SC_ONE;
            end
        end else if (w_scale < SC_MIN) begin
            w_scale = SC_MIN;
        end
    end

    // Final step: high partial product plus the shifted low partial product
    always_comb begin
        w_sum = SUM_W'(r_acc) + SUM_W'(w_prod[35:16]);
        w_sat = |w_sum[SUM_W-1:STEP_W];
        w_res = w_sat ? STEP_MAX : w_sum[STEP_W-1:0];
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_last_rej  = r_last_rej;
        n_out       = r_out;
        n_step_in   = r_step_in;
        n_accept    = r_accept;
        n_zero      = r_zero;
        n_u         = r_u;
        n_scale     = r_scale;
        n_acc       = r_acc;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_step_in = i_in.tried_step;
                    n_accept  = i_in.error_estimate <= ERR_ONE;
                    n_zero    = i_in.error_estimate == '0;
                    n_state   = (i_in.error_estimate == '0) ? S_SCALE : S_NORM;
                end
            end
            S_NORM: begin
                if (w_norm_stat.done) begin
                    n_u     = EXP_W'(w_norm_stat.lead_zeros) + 6'd1;
                    n_state = S_ROOT;
                end
            end
            S_ROOT:     n_state = S_MUL_TR;
            S_MUL_TR:   n_state = S_MUL_NINE;
            S_MUL_NINE: n_state = S_SCALE;
            S_SCALE: begin
                n_scale = w_scale;
                n_state = S_MUL_HI;
            end
            S_MUL_HI:   n_state = S_MUL_LO;
            S_MUL_LO: begin
                n_acc   = w_prod[ACC_W-1:0];
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free or being emptied
                if (!r_out_valid || !i_out_stall) begin
                    n_out.step_accepted  = r_accept;
                    n_out.new_step       = w_res;
                    n_out.step_saturated = w_res == STEP_MAX;
                    n_out_valid          = 1'b1;
                    n_last_rej           = !r_accept;
                    n_state              = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_last_rej  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_last_rej  <= n_last_rej;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out     <= n_out;
        r_step_in <= n_step_in;
        r_accept  <= n_accept;
        r_zero    <= n_zero;
        r_u       <= n_u;
        r_scale   <= n_scale;
        r_acc     <= n_acc;
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== hdl/ossc_normalizer.sv =====
// Iterative leading-zero normaliser: one conditional shift of 16, 8, 4, 2, 1 per cycle.
`timescale 1ns / 1ps
module ossc_normalizer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [ossc_pkg::ERR_W-1:0]  i_value,
    output ossc_pkg::t_norm_status      o_status,
    output logic [ossc_pkg::ERR_W-1:0]  o_mant
);
    import ossc_pkg::*;

    localparam int STEPS = 5;
    localparam logic [2:0] LAST_STEP = 3'(STEPS - 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [2:0]       r_step, n_step;
    logic [LZ_W-1:0]  r_lz, n_lz;
    logic [ERR_W-1:0] r_mant, n_mant;

    logic [LZ_W-1:0]  w_sh;
    logic [ERR_W-1:0] w_top_mask;
    logic             w_top_zero;

    always_comb begin
        w_sh       = LZ_W'(5'd16 >> r_step);
        w_top_mask = ~({ERR_W{1'b1}} >> w_sh);
        w_top_zero = (r_mant & w_top_mask) == '0;

        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_lz   = r_lz;
        n_mant = r_mant;
        if (i_load) begin
            n_busy = 1'b1;
            n_step = '0;
            n_lz   = '0;
            n_mant = i_value;
        end else if (r_busy) begin
            if (w_top_zero) begin
                n_mant = r_mant << w_sh;
                n_lz   = r_lz + w_sh;
            end
            n_step = r_step + 3'd1;
            if (r_step == LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lz   <= n_lz;
        r_mant <= n_mant;
    end

    assign o_status.done       = r_done;
    assign o_status.lead_zeros = r_lz;
    assign o_mant              = r_mant;

endmodule

// ===== hdl/ossc_root_rom.sv =====
// Constant table of eighth roots of the reciprocal bucket midpoints, with registered read.
`timescale 1ns / 1ps
module ossc_root_rom #(
    parameter int ROOT_TABLE_BITS = ossc_pkg::C_ROOT_TABLE_BITS
) (
    input  logic                         i_clk,
    input  logic [ROOT_TABLE_BITS-1:0]   i_addr,
    output logic [ossc_pkg::ROOT_W-1:0]  o_data
);
    import ossc_pkg::*;

    localparam int DEPTH = 1 << ROOT_TABLE_BITS;

    logic [ROOT_W-1:0] w_rom [0:DEPTH-1];
    logic [ROOT_W-1:0] r_data;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_entry
        localparam logic [ROOT_W-1:0] ENTRY = root_entry(ROOT_TABLE_BITS, gi);
        assign w_rom[gi] = ENTRY;
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_rom[i_addr];
    end

    assign o_data = r_data;

endmodule

// ===== hdl/ossc_mul_unit.sv =====
// Shared unsigned multiplier with registered product.
`timescale 1ns / 1ps
module ossc_mul_unit (
    input  logic                          i_clk,
    input  logic [ossc_pkg::MUL_A_W-1:0]  i_a,
    input  logic [ossc_pkg::MUL_B_W-1:0]  i_b,
    output logic [ossc_pkg::MUL_P_W-1:0]  o_prod
);
    import ossc_pkg::*;

    logic [MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ===== hdl/ossc_checker.sv =====
// Port-level checks of the step size controller and their binding.
`timescale 1ns / 1ps
module ossc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input ossc_pkg::t_out_item o_out
);
    import ossc_pkg::*;

    // A stalled result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("result beat changed while stalled");

    // One item at a time: the input closes right after a beat is taken
    a_in_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input open in the cycle after an accepted beat");

    // Saturation flag matches the step value
    a_sat_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.step_saturated == (o_out.new_step == STEP_MAX)))
        else $error("saturation flag disagrees with new_step");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind ode_step_size_controller_unit ossc_checker u_ossc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
